### sv/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg: shared definitions of the text console character writer
// Screen geometry, character codes, register indexes and the command and
// status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam int MAX_COLUMNS = 80;
    localparam int MAX_ROWS    = 25;
    localparam int CELL_COUNT  = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W      = $clog2(CELL_COUNT);

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam logic [CHAR_W-1:0] CR_CHAR    = 8'd13;
    localparam logic [CHAR_W-1:0] LF_CHAR    = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h1e;

    localparam logic [COL_W-1:0] COLS_RESET = 7'(MAX_COLUMNS);
    localparam logic [ROW_W-1:0] ROWS_RESET = 5'(MAX_ROWS);

    // Input item layout on the slave tdata bus
    localparam int IN_DATA_W  = 24;
    localparam int IN_CHAR_LO = 0;
    localparam int IN_ROW_LO  = IN_CHAR_LO + CHAR_W;
    localparam int IN_COL_LO  = IN_ROW_LO + ROW_W;

    // Result layout on the master tdata bus
    localparam int OUT_DATA_W = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMNS   = 2'd0,
        CFG_ROWS      = 2'd1,
        CFG_ATTRIBUTE = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg_index;

    typedef enum logic {
        CMD_PUT  = 1'b0,
        CMD_READ = 1'b1
    } t_command;

    // Controller to datapath
    typedef struct packed {
        logic latch;       // capture the accepted item
        logic exec;        // update cursor, store char or issue cell read
        logic clear_step;  // write one reset cell of the clearing pass
        logic copy_rd;     // read a cell one row below its scroll target
        logic copy_wr;     // write the read cell one row up, advance scan
        logic blank_wr;    // blank one bottom-row cell, advance scan
        logic load_out;    // load the result register
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_scroll;
        logic single_row;
        logic copy_last;
        logic blank_last;
        logic clear_last;
    } t_ctrl_status;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row) * ADDR_W'(MAX_COLUMNS);
        return base + ADDR_W'(col);
    endfunction

endpackage

### sv/text_console_char_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_char_writer_top: text console character writer
// Cursor-driven put of characters into an 80 x 25 screen store with
// carriage return, line feed, wrap and scroll, plus cell reads for refresh.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole 2000-cell store to character 0 with
// attribute 0x1e, one cell per clock, and keeps s_axis_tready low for the
// whole sweep; configuration writes are taken during the sweep. Each beat
// then yields exactly one result beat. A read or a put that does not scroll
// passes through the execute and finish states before the block is ready
// again. A put that scrolls walks the store cell by cell: a read and a write
// for every cell of rows 1..h-1, then a write for every cell of the bottom
// row (w columns and h rows in use; a single-row window takes only the
// bottom-row writes). The result sits in an output register, so the next
// beat is accepted while the previous result still waits.
// Write the geometry and attribute registers only while the block is idle.
// ----------------------------------------------------------------------------
module text_console_char_writer_top
    import tccw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port: 0 columns, 1 rows, 2 attribute
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] character, [12:8] read_row,
                                                 // [19:13] read_col, [23:20] zero
    input  logic                  s_axis_tuser,  // [0] command: 0 put, 1 read
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // [7:0] cell_char, [15:8] cell_attr,
                                                 // [22:16] cursor_col, [27:23] cursor_row,
                                                 // [28] scrolled, [31:29] zero
);

    t_ctrl_cmd         cmd;
    t_ctrl_status      status;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;

    // sequencing: clear sweep, execute, scroll copy, blank, result hand-off
    tccw_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    // store, cursor, geometry and result register
    tccw_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item_cmd   (s_axis_tuser),
        .i_item_char  (s_axis_tdata[IN_CHAR_LO +: CHAR_W]),
        .i_item_row   (s_axis_tdata[IN_ROW_LO +: ROW_W]),
        .i_item_col   (s_axis_tdata[IN_COL_LO +: COL_W]),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_cell_char  (cell_char),
        .o_cell_attr  (cell_attr),
        .o_cursor_col (cursor_col),
        .o_cursor_row (cursor_row),
        .o_scrolled   (scrolled)
    );

    // pack the result beat, lowest field first
    assign m_axis_tdata = {3'b000, scrolled, cursor_row, cursor_col, cell_attr, cell_char};

endmodule

### sv/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// tccw_ctrl: sequencing controller
// Runs the clearing pass, item execution, the scroll copy and blank sweeps,
// and the handshakes of both stream sides.
// ----------------------------------------------------------------------------
module tccw_ctrl
    import tccw_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  t_ctrl_status i_status,
    output t_ctrl_cmd    o_cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR   = 7'b0000001,
        ST_IDLE    = 7'b0000010,
        ST_EXEC    = 7'b0000100,
        ST_COPY_RD = 7'b0001000,
        ST_COPY_WR = 7'b0010000,
        ST_BLANK   = 7'b0100000,
        ST_FINISH  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !m_axis_tready;
        o_cmd       = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (!i_status.need_scroll) begin
                    n_state = ST_FINISH;
                end else if (i_status.single_row) begin
                    n_state = ST_BLANK;
                end else begin
                    n_state = ST_COPY_RD;
                end
            end
            ST_COPY_RD: begin
                o_cmd.copy_rd = 1'b1;
                n_state       = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                o_cmd.copy_wr = 1'b1;
                n_state       = i_status.copy_last ? ST_BLANK : ST_COPY_RD;
            end
            ST_BLANK: begin
                o_cmd.blank_wr = 1'b1;
                if (i_status.blank_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### sv/tccw_datapath.sv
// ----------------------------------------------------------------------------
// tccw_datapath: screen store, cursor and configuration
// Holds the cell memory, the cursor, the geometry registers, the scroll scan
// counters and the result register.
// ----------------------------------------------------------------------------
module tccw_datapath
    import tccw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_item_cmd,
    input  logic [CHAR_W-1:0]     i_item_char,
    input  logic [ROW_W-1:0]      i_item_row,
    input  logic [COL_W-1:0]      i_item_col,
    input  t_ctrl_cmd             i_cmd,
    output t_ctrl_status          o_status,
    output logic [CHAR_W-1:0]     o_cell_char,
    output logic [ATTR_W-1:0]     o_cell_attr,
    output logic [COL_W-1:0]      o_cursor_col,
    output logic [ROW_W-1:0]      o_cursor_row,
    output logic                  o_scrolled
);

    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] r_rd_data;

    logic [COL_W-1:0]  r_cfg_cols;
    logic [ROW_W-1:0]  r_cfg_rows;
    logic [ATTR_W-1:0] r_cfg_attr;

    logic [COL_W-1:0]  r_cur_col, n_cur_col;
    logic [ROW_W-1:0]  r_cur_row, n_cur_row;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ROW_W-1:0]  r_scan_row;
    logic [COL_W-1:0]  r_scan_col;
    logic              r_scrolled;

    logic              r_item_cmd;
    logic [CHAR_W-1:0] r_item_char;
    logic [ROW_W-1:0]  r_item_row;
    logic [COL_W-1:0]  r_item_col;
    logic              r_item_oob;

    logic [CHAR_W-1:0] r_out_char;
    logic [ATTR_W-1:0] r_out_attr;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic              r_out_scrolled;

    logic [COL_W-1:0]  width_eff;
    logic [ROW_W-1:0]  height_eff;
    logic [COL_W-1:0]  col_sat, col_inc;
    logic [ROW_W-1:0]  row_sat, row_inc;
    logic              is_cr, is_lf, is_put, is_read, col_wrap, row_over;
    logic              scan_col_end, scan_row_end;

    logic              we, re;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [CELL_W-1:0] wdata;

    // Clamp geometry into 1..max
    always_comb begin
        if (r_cfg_cols == '0) begin
            width_eff = COL_W'(1);
        end else if (r_cfg_cols > COLS_RESET) begin
            width_eff = COLS_RESET;
        end else begin
            width_eff = r_cfg_cols;
        end
        if (r_cfg_rows == '0) begin
            height_eff = ROW_W'(1);
        end else if (r_cfg_rows > ROWS_RESET) begin
            height_eff = ROWS_RESET;
        end else begin
            height_eff = r_cfg_rows;
        end
    end

    // Cursor saturated into the window, then stepped
    assign col_sat  = (r_cur_col >= width_eff)  ? width_eff - COL_W'(1)  : r_cur_col;
    assign row_sat  = (r_cur_row >= height_eff) ? height_eff - ROW_W'(1) : r_cur_row;
    assign col_inc  = col_sat + COL_W'(1);
    assign row_inc  = row_sat + ROW_W'(1);
    assign col_wrap = (col_inc >= width_eff);
    assign row_over = (row_inc >= height_eff);

    assign is_read = (r_item_cmd == CMD_READ);
    assign is_put  = !is_read;
    assign is_cr   = (r_item_char == CR_CHAR);
    assign is_lf   = (r_item_char == LF_CHAR);

    always_comb begin
        n_cur_col = col_sat;
        n_cur_row = row_sat;
        if (is_cr) begin
            n_cur_col = '0;
        end else if (is_lf) begin
            n_cur_col = '0;
            n_cur_row = row_over ? row_sat : row_inc;
        end else if (col_wrap) begin
            n_cur_col = '0;
            n_cur_row = row_over ? row_sat : row_inc;
        end else begin
            n_cur_col = col_inc;
        end
    end

    assign scan_col_end = (r_scan_col + COL_W'(1) == width_eff);
    assign scan_row_end = ({1'b0, r_scan_row} + (ROW_W+1)'(1) == {1'b0, height_eff});

    assign o_status.need_scroll = is_put && !is_cr && row_over && (is_lf || col_wrap);
    assign o_status.single_row  = (height_eff == ROW_W'(1));
    assign o_status.copy_last   = scan_col_end && scan_row_end;
    assign o_status.blank_last  = scan_col_end;
    assign o_status.clear_last  = (r_clr_addr == ADDR_W'(CELL_COUNT - 1));

    // Memory port select
    always_comb begin
        we    = 1'b0;
        waddr = cell_addr(r_scan_row - ROW_W'(1), r_scan_col);
        wdata = r_rd_data;
        re    = 1'b0;
        raddr = cell_addr(r_scan_row, r_scan_col);
        if (i_cmd.clear_step) begin
            we    = 1'b1;
            waddr = r_clr_addr;
            wdata = {RESET_ATTR, CHAR_W'(0)};
        end else if (i_cmd.exec) begin
            we    = is_put && !is_cr && !is_lf;
            waddr = cell_addr(row_sat, col_sat);
            wdata = {r_cfg_attr, r_item_char};
            re    = is_read && !r_item_oob;
            raddr = cell_addr(r_item_row, r_item_col);
        end else if (i_cmd.copy_rd) begin
            re = 1'b1;
        end else if (i_cmd.copy_wr) begin
            we = 1'b1;
        end else if (i_cmd.blank_wr) begin
            we    = 1'b1;
            waddr = cell_addr(height_eff - ROW_W'(1), r_scan_col);
            wdata = {r_cfg_attr, BLANK_CHAR};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd_data <= mem[raddr];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= COLS_RESET;
            r_cfg_rows <= ROWS_RESET;
            r_cfg_attr <= RESET_ATTR;
            r_cur_col  <= '0;
            r_cur_row  <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_COLUMNS:   r_cfg_cols <= i_cfg_data[COL_W-1:0];
                    CFG_ROWS:      r_cfg_rows <= i_cfg_data[ROW_W-1:0];
                    CFG_ATTRIBUTE: r_cfg_attr <= i_cfg_data[ATTR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.exec && is_put) begin
                r_cur_col <= n_cur_col;
                r_cur_row <= n_cur_row;
            end
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    // Item, scan and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item_cmd  <= i_item_cmd;
            r_item_char <= i_item_char;
            r_item_row  <= i_item_row;
            r_item_col  <= i_item_col;
            r_item_oob  <= (i_item_row >= ROWS_RESET) || (i_item_col >= COLS_RESET);
        end
        if (i_cmd.exec) begin
            r_scrolled <= o_status.need_scroll;
            r_scan_row <= ROW_W'(1);
            r_scan_col <= '0;
        end
        if (i_cmd.copy_wr) begin
            if (scan_col_end) begin
                r_scan_col <= '0;
                r_scan_row <= r_scan_row + ROW_W'(1);
            end else begin
                r_scan_col <= r_scan_col + COL_W'(1);
            end
        end
        if (i_cmd.blank_wr) begin
            r_scan_col <= r_scan_col + COL_W'(1);
        end
        if (i_cmd.load_out) begin
            r_out_char     <= (is_read && !r_item_oob) ? r_rd_data[CHAR_W-1:0] : '0;
            r_out_attr     <= (is_read && !r_item_oob) ? r_rd_data[CELL_W-1:CHAR_W] : '0;
            r_out_col      <= r_cur_col;
            r_out_row      <= r_cur_row;
            r_out_scrolled <= is_put && r_scrolled;
        end
    end

    assign o_cell_char  = r_out_char;
    assign o_cell_attr  = r_out_attr;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_scrolled   = r_out_scrolled;

endmodule
